// ===== design/scms_pkg.sv =====
// Shared types and constants for the spray-clean motion sequencer.
// Used by the core, the register file, the top level and the checker.
package scms_pkg;

  localparam int SEQ_W = 3;

  localparam logic [SEQ_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [SEQ_W-1:0] ST_HOMING  = 3'd1;
  localparam logic [SEQ_W-1:0] ST_PARKED  = 3'd2;
  localparam logic [SEQ_W-1:0] ST_WAITING = 3'd3;
  localparam logic [SEQ_W-1:0] ST_SPRAY   = 3'd4;
  localparam logic [SEQ_W-1:0] ST_OSC     = 3'd5;

  localparam logic [7:0] FAN_OFF   = 8'd0;
  localparam logic [7:0] FAN_PRIME = 8'd128;
  localparam logic [7:0] FAN_MAX   = 8'd255;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_INT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SWEEP_INT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STABILIZE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PARK_POS   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_POS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STEPS_SWP  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SWEEPS_TOT = 3'd7;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_USED_W  = 33;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] step_interval_ms;
    logic [15:0] sweep_interval_ms;
    logic [15:0] stabilize_ms;
    logic [14:0] park_position;
    logic [14:0] center_position;
    logic [7:0]  steps_per_sweep;
    logic [7:0]  sweeps_total;
  } cfg_t;

  typedef struct packed {
    logic limit_raw_pressed;
    logic spray_valve_on;
    logic flow_present;
  } sample_t;

  typedef struct packed {
    logic [15:0]      motor_position;
    logic             ultrasonic_on;
    logic [7:0]       fan_level;
    logic             yellow_led;
    logic             green_led;
    logic             step_toward_far;
    logic             step_pulse;
    logic             motor_enable;
    logic [SEQ_W-1:0] seq_code;
  } result_t;

endpackage

// ===== design/spray_clean_motion_sequencer.sv =====
// Top level of the spray-clean motion sequencer: input and result registers
// around scms_core, plus the scms_cfg_regs register file. Depends on scms_pkg.
//
// Usage: one input word per millisecond tick on in_* (limit switch, spray
// valve and flow levels); one result word per input word on out_* (state,
// motor enable/step/direction, LEDs, fan level, ultrasonic, position).
// Settings are written over cfg_* while no word is in flight.
// A word accepted into the input register passes through the core into the
// result register, which shows it on out_*. Throughput: one word per cycle
// while the receiver is not stalling, set by the single pass through the core.
// The input register is freed whenever the result register is empty or is
// being taken, so a waiting result does not block the next input word.
// When the receiver stalls, out_tdata holds and in_tready drops once both
// registers are full.
// Reset (rst_n low, synchronous) empties both registers, returns the
// sequencer to idle at position zero and loads the default settings.
module spray_clean_motion_sequencer #(
  parameter int POSITION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] limit_raw_pressed, [1] spray_valve_on, [2] flow_present, [7:3] zero
  input  logic [scms_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] seq_code, [3] motor_enable, [4] step_pulse, [5] step_toward_far,
  // [6] green_led, [7] yellow_led, [15:8] fan_level, [16] ultrasonic_on,
  // [32:17] motor_position, [39:33] zero
  output logic [scms_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [4:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  scms_pkg::cfg_t     cfg;
  scms_pkg::sample_t  sample_r;
  scms_pkg::result_t  result, result_r;
  logic               in_valid_r;
  logic               out_valid_r;
  logic               advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r.limit_raw_pressed <= in_tdata[0];
      sample_r.spray_valve_on    <= in_tdata[1];
      sample_r.flow_present      <= in_tdata[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(scms_pkg::OUT_TDATA_W - scms_pkg::OUT_USED_W){1'b0}}, result_r};

  scms_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  scms_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .sample  (sample_r),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

// ===== design/scms_cfg_regs.sv =====
// APB-style register file for the sequencer settings.
// Depends on scms_pkg for the register indexes and cfg_t.
module scms_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output scms_pkg::cfg_t      cfg
);

  scms_pkg::cfg_t                     cfg_r;
  logic [scms_pkg::REG_IDX_W-1:0]     idx;
  logic                               wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= 8'd20;
      cfg_r.step_interval_ms  <= 16'd50;
      cfg_r.sweep_interval_ms <= 16'd10000;
      cfg_r.stabilize_ms      <= 16'd2000;
      cfg_r.park_position     <= 15'd7;
      cfg_r.center_position   <= 15'd26;
      cfg_r.steps_per_sweep   <= 8'd16;
      cfg_r.sweeps_total      <= 8'd20;
    end else if (wr_en) begin
      unique case (idx)
        scms_pkg::REG_DEBOUNCE:   cfg_r.debounce_ms       <= pwdata[7:0];
        scms_pkg::REG_STEP_INT:   cfg_r.step_interval_ms  <= pwdata[15:0];
        scms_pkg::REG_SWEEP_INT:  cfg_r.sweep_interval_ms <= pwdata[15:0];
        scms_pkg::REG_STABILIZE:  cfg_r.stabilize_ms      <= pwdata[15:0];
        scms_pkg::REG_PARK_POS:   cfg_r.park_position     <= pwdata[14:0];
        scms_pkg::REG_CENTER_POS: cfg_r.center_position   <= pwdata[14:0];
        scms_pkg::REG_STEPS_SWP:  cfg_r.steps_per_sweep   <= pwdata[7:0];
        scms_pkg::REG_SWEEPS_TOT: cfg_r.sweeps_total      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      scms_pkg::REG_DEBOUNCE:   prdata = {24'd0, cfg_r.debounce_ms};
      scms_pkg::REG_STEP_INT:   prdata = {16'd0, cfg_r.step_interval_ms};
      scms_pkg::REG_SWEEP_INT:  prdata = {16'd0, cfg_r.sweep_interval_ms};
      scms_pkg::REG_STABILIZE:  prdata = {16'd0, cfg_r.stabilize_ms};
      scms_pkg::REG_PARK_POS:   prdata = {17'd0, cfg_r.park_position};
      scms_pkg::REG_CENTER_POS: prdata = {17'd0, cfg_r.center_position};
      scms_pkg::REG_STEPS_SWP:  prdata = {24'd0, cfg_r.steps_per_sweep};
      scms_pkg::REG_SWEEPS_TOT: prdata = {24'd0, cfg_r.sweeps_total};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/scms_core.sv =====
// Debounce, transition rules and state actions for one tick.
// Holds the sequencer state; depends on scms_pkg.
module scms_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  scms_pkg::sample_t    sample,
  input  scms_pkg::cfg_t       cfg,
  output scms_pkg::result_t    result
);

  localparam int CMP_W = POSITION_BITS + 16;
  localparam logic signed [POSITION_BITS-1:0] POS_TOP =
    {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_BOT =
    {1'b1, {(POSITION_BITS-1){1'b0}}};

  logic [scms_pkg::SEQ_W-1:0]       seq_r, seq_nxt, seq_cur;
  logic signed [POSITION_BITS-1:0]  pos_r, pos_nxt, pos_t;
  logic [15:0]                      tss_r, tss_nxt, tss_inc;
  logic [15:0]                      tis_r, tis_nxt, tis_inc;
  logic [7:0]                       swp_cnt_r, swp_cnt_nxt, cnt_inc;
  logic [7:0]                       swp_done_r, swp_done_nxt;
  logic                             dir_r, dir_nxt;
  logic                             last_r, last_nxt;
  logic [7:0]                       stab_r, stab_nxt;
  logic                             pressed_r, pressed_nxt;

  logic signed [CMP_W-1:0]          pos_c, park_c, center_c;
  logic                             at_park, below_center, above_center;
  logic                             step_now, step_far;
  logic                             en, green, yellow, us;
  logic [7:0]                       fan;
  logic [CMP_W-1:0]                 pos_ext;

  always_comb begin
    seq_cur      = (seq_r > scms_pkg::ST_OSC) ? scms_pkg::ST_IDLE : seq_r;
    step_now     = 1'b0;
    step_far     = 1'b0;
    en           = 1'b0;
    green        = 1'b0;
    yellow       = 1'b0;
    us           = 1'b0;
    fan          = scms_pkg::FAN_OFF;
    swp_cnt_nxt  = swp_cnt_r;
    swp_done_nxt = swp_done_r;
    dir_nxt      = dir_r;
    pos_t        = pos_r;

    // debounce
    if (sample.limit_raw_pressed != last_r) begin
      last_nxt = sample.limit_raw_pressed;
      stab_nxt = 8'd0;
    end else begin
      last_nxt = last_r;
      stab_nxt = (stab_r == 8'hFF) ? stab_r : stab_r + 8'd1;
    end
    pressed_nxt = (stab_nxt >= cfg.debounce_ms) ? last_nxt : pressed_r;

    tss_inc = (tss_r == 16'hFFFF) ? tss_r : tss_r + 16'd1;
    tis_inc = (tis_r == 16'hFFFF) ? tis_r : tis_r + 16'd1;
    tss_nxt = tss_inc;
    tis_nxt = tis_inc;
    seq_nxt = seq_cur;

    park_c   = CMP_W'(cfg.park_position);
    center_c = CMP_W'(cfg.center_position);
    pos_c    = CMP_W'(pos_r);
    at_park  = pos_c >= park_c;

    // transitions
    unique case (seq_cur)
      scms_pkg::ST_IDLE: begin
        if (sample.spray_valve_on) begin
          seq_nxt = scms_pkg::ST_HOMING;
        end
      end
      scms_pkg::ST_HOMING: begin
        if (pressed_nxt) begin
          pos_t   = '0;
          seq_nxt = scms_pkg::ST_PARKED;
        end
      end
      scms_pkg::ST_PARKED: begin
        if (at_park && sample.spray_valve_on) begin
          if (!sample.flow_present) begin
            seq_nxt = scms_pkg::ST_WAITING;
          end else begin
            seq_nxt = scms_pkg::ST_SPRAY;
          end
        end
      end
      scms_pkg::ST_WAITING: begin
        if (!sample.spray_valve_on) begin
          seq_nxt = scms_pkg::ST_PARKED;
        end else if (sample.flow_present) begin
          seq_nxt = scms_pkg::ST_SPRAY;
        end
      end
      scms_pkg::ST_SPRAY: begin
        if (!sample.spray_valve_on || !sample.flow_present) begin
          seq_nxt = scms_pkg::ST_IDLE;
        end else if (tis_inc >= cfg.stabilize_ms && pos_c >= center_c) begin
          seq_nxt = scms_pkg::ST_OSC;
        end
      end
      default: begin
        if (!sample.spray_valve_on || !sample.flow_present ||
            swp_done_r >= cfg.sweeps_total) begin
          seq_nxt = scms_pkg::ST_IDLE;
        end
      end
    endcase

    if (seq_nxt != seq_cur) begin
      tis_nxt = 16'd0;
    end
    if (seq_nxt == scms_pkg::ST_SPRAY && seq_cur != scms_pkg::ST_SPRAY) begin
      swp_done_nxt = 8'd0;
      dir_nxt      = 1'b0;
      swp_cnt_nxt  = 8'd0;
    end

    pos_c        = CMP_W'(pos_t);
    below_center = pos_c < center_c;
    above_center = pos_c > center_c;
    cnt_inc      = swp_cnt_nxt + 8'd1;

    // actions
    unique case (seq_nxt)
      scms_pkg::ST_IDLE: ;
      scms_pkg::ST_HOMING: begin
        en     = 1'b1;
        yellow = 1'b1;
        if (tss_inc >= cfg.step_interval_ms) begin
          step_now = 1'b1;
          tss_nxt  = 16'd0;
        end
      end
      scms_pkg::ST_PARKED: begin
        green = 1'b1;
        if (pos_c < park_c) begin
          en = 1'b1;
          if (tss_inc >= cfg.step_interval_ms) begin
            step_now = 1'b1;
            step_far = 1'b1;
            tss_nxt  = 16'd0;
          end
        end
      end
      scms_pkg::ST_WAITING: begin
        yellow = 1'b1;
        fan    = scms_pkg::FAN_PRIME;
      end
      scms_pkg::ST_SPRAY: begin
        fan   = scms_pkg::FAN_MAX;
        us    = 1'b1;
        green = 1'b1;
        en    = 1'b1;
        if (tss_inc >= cfg.step_interval_ms) begin
          step_now = below_center || above_center;
          step_far = below_center;
          tss_nxt  = 16'd0;
        end
      end
      default: begin
        en    = 1'b1;
        fan   = scms_pkg::FAN_MAX;
        us    = 1'b1;
        green = 1'b1;
        if (tss_inc >= cfg.sweep_interval_ms) begin
          step_now    = 1'b1;
          step_far    = dir_nxt;
          tss_nxt     = 16'd0;
          swp_cnt_nxt = cnt_inc;
          if (cnt_inc >= cfg.steps_per_sweep) begin
            swp_cnt_nxt  = 8'd0;
            dir_nxt      = !dir_nxt;
            swp_done_nxt = (swp_done_nxt == 8'hFF) ? swp_done_nxt
                                                   : swp_done_nxt + 8'd1;
          end
        end
      end
    endcase

    pos_nxt = pos_t;
    if (step_now) begin
      if (step_far) begin
        if (pos_t != POS_TOP) pos_nxt = pos_t + POSITION_BITS'(1);
      end else begin
        if (pos_t != POS_BOT) pos_nxt = pos_t - POSITION_BITS'(1);
      end
    end

    pos_ext = CMP_W'(pos_nxt);

    result.seq_code        = seq_nxt;
    result.motor_enable    = en;
    result.step_pulse      = step_now;
    result.step_toward_far = step_far;
    result.green_led       = green;
    result.yellow_led      = yellow;
    result.fan_level       = fan;
    result.ultrasonic_on   = us;
    result.motor_position  = pos_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= scms_pkg::ST_IDLE;
      pos_r      <= '0;
      tss_r      <= '0;
      tis_r      <= '0;
      swp_cnt_r  <= '0;
      swp_done_r <= '0;
      dir_r      <= 1'b0;
      last_r     <= 1'b0;
      stab_r     <= '0;
      pressed_r  <= 1'b0;
    end else if (advance) begin
      seq_r      <= seq_nxt;
      pos_r      <= pos_nxt;
      tss_r      <= tss_nxt;
      tis_r      <= tis_nxt;
      swp_cnt_r  <= swp_cnt_nxt;
      swp_done_r <= swp_done_nxt;
      dir_r      <= dir_nxt;
      last_r     <= last_nxt;
      stab_r     <= stab_nxt;
      pressed_r  <= pressed_nxt;
    end
  end

endmodule

// ===== design/scms_checker.sv =====
// Port-level checks for spray_clean_motion_sequencer, attached by bind.
// Depends on scms_pkg for the state codes and fan levels.
module scms_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [scms_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_step_implies_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[5] || out_tdata[4]) && (!out_tdata[4] || out_tdata[3]))
    else $error("step or direction without motor enable");

  a_fan_us: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[15:8] == scms_pkg::FAN_MAX) == out_tdata[16]) &&
                   (out_tdata[15:8] == scms_pkg::FAN_OFF ||
                    out_tdata[15:8] == scms_pkg::FAN_PRIME ||
                    out_tdata[15:8] == scms_pkg::FAN_MAX))
    else $error("fan level and ultrasonic disagree");

  a_code_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= scms_pkg::ST_OSC && out_tdata[39:33] == 7'd0 &&
                   cfg_pready)
    else $error("bad state code or padding");

endmodule

bind spray_clean_motion_sequencer scms_checker u_scms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
